// ===== src/mha_pkg.sv =====
// Package for the multiset hash accumulator: hash constants, lane seeds,
// back-end state encoding and shared types. No dependencies.
`default_nettype none

package mha_pkg;

  localparam int MAX_LANES = 8;
  localparam int CFG_IDX_W = 8;
  localparam int DIV_STEPS = 34;
  localparam int STEP_W    = 6;

  localparam logic [31:0] C_SCR1    = 32'hcc9e2d51;
  localparam logic [31:0] C_SCR2    = 32'h1b873593;
  localparam logic [31:0] C_MIX_ADD = 32'he6546b64;
  localparam logic [31:0] C_FMIX1   = 32'h85ebca6b;
  localparam logic [31:0] C_FMIX2   = 32'hc2b2ae35;
  localparam logic [31:0] MOD_RESET = 32'hfffffffb;

  localparam logic [MAX_LANES-1:0][31:0] LANE_SEED = {
    32'h8d7c6b5a, 32'h0f5e2a8b, 32'h1a6b3d9c, 32'h2b8a4c7e,
    32'h3c9d5e8f, 32'h4f2e6a1b, 32'h7feb352d, 32'h9747b28c
  };

  // Lane index times the first finalizer constant, modulo 2^32.
  localparam logic [MAX_LANES-1:0][31:0] LANE_DELTA = {
    32'ha97288ed, 32'h2386be82, 32'h9d9af417, 32'h17af29ac,
    32'h91c35f41, 32'h0bd794d6, 32'h85ebca6b, 32'h00000000
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_FIN,
    ST_DIV1,
    ST_ADJ,
    ST_DIV2,
    ST_OUT
  } back_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

// ===== src/mha_ifs.sv =====
// Channel interfaces of the multiset hash accumulator: word requests,
// result requests and configuration writes. Depends on mha_pkg.
`default_nettype none

interface mha_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] data_word;
  logic [2:0]  valid_bytes;
  logic        last_word;
  modport source (output valid, mode, data_word, valid_bytes, last_word, input ready);
  modport sink   (input valid, mode, data_word, valid_bytes, last_word, output ready);
endinterface

interface mha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sum_lane0;
  logic [31:0] sum_lane1;
  logic [31:0] sum_lane2;
  logic [31:0] sum_lane3;
  logic [31:0] sum_lane4;
  logic [31:0] sum_lane5;
  logic [31:0] sum_lane6;
  logic [31:0] sum_lane7;
  modport source (output valid, sum_lane0, sum_lane1, sum_lane2, sum_lane3,
                  sum_lane4, sum_lane5, sum_lane6, sum_lane7, input ready);
  modport sink   (input valid, sum_lane0, sum_lane1, sum_lane2, sum_lane3,
                  sum_lane4, sum_lane5, sum_lane6, sum_lane7, output ready);
endinterface

interface mha_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [mha_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/multiset_hash_accumulator_core.sv =====
// Top level of the multiset hash accumulator: modulus registers, front
// end, queue and back end. Depends on mha_pkg, mha_ifs, mha_front,
// mha_fifo and mha_back.
//
// Usage: records stream in on in_req as 32-bit little-endian words, one
// word per cycle when ready is high; last_word marks the final word and
// valid_bytes (0..4) its byte count, mode selects add or remove. For each
// record one result with the eight running lane sums appears on out_rsp.
// Lanes at or above LANES read zero. cfg_wr writes the modulus of lane
// index and is always ready; write only while no record is in flight.
// Words pass a two-stage scramble pipeline and are folded into the lane
// hashes behind it. A record's result is computed by three finalizer steps
// plus two 34-step bit-serial remainder passes in every lane. Records are
// finished one at a time by the back end; a two-entry queue lets words
// keep streaming meanwhile.
// Reset (synchronous, rst_n low) clears sums, record state and the
// queue, and sets all moduli to 4294967291. When out_rsp stalls the result
// holds, the back end waits, and once the queue fills in_req drops ready.
`default_nettype none

module multiset_hash_accumulator_core #(
  parameter int LANES = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mha_in_if.sink    in_req,
  mha_out_if.source out_rsp,
  mha_cfg_if.sink   cfg_wr
);
  import mha_pkg::*;

  localparam int QW = LANES * 32 + 33;

  logic [LANES-1:0][31:0]     mod_r;
  fifo_stat_t                 q_stat;
  logic                       q_push, q_pop, f_mode, b_mode;
  logic [LANES-1:0][31:0]     f_hash, b_hash;
  logic [31:0]                f_len, b_len;
  logic [QW-1:0]              b_word;
  logic [LANES-1:0][31:0]     sums;
  logic [MAX_LANES-1:0][31:0] sums_all;

  // Modulus registers.
  assign cfg_wr.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANES; i++) begin
        mod_r[i] <= MOD_RESET;
      end
    end else begin
      for (int i = 0; i < LANES; i++) begin
        if (cfg_wr.valid && cfg_wr.index == CFG_IDX_W'(i)) begin
          mod_r[i] <= cfg_wr.data;
        end
      end
    end
  end

  mha_front #(.LANES(LANES)) u_front (
    .clk(clk), .rst_n(rst_n), .in_req(in_req), .q_stat(q_stat),
    .q_push(q_push), .q_hash(f_hash), .q_len(f_len), .q_mode(f_mode)
  );

  mha_fifo #(.W(QW)) u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push),
    .push_data({f_mode, f_len, f_hash}), .pop(q_pop),
    .pop_data(b_word), .stat(q_stat)
  );

  assign b_mode = b_word[QW-1];
  assign b_len  = b_word[QW-2 -: 32];
  assign b_hash = b_word[LANES*32-1:0];

  mha_back #(.LANES(LANES)) u_back (
    .clk(clk), .rst_n(rst_n), .q_stat(q_stat), .q_pop(q_pop),
    .q_hash(b_hash), .q_len(b_len), .q_mode(b_mode), .modulus(mod_r),
    .out_valid(out_rsp.valid), .out_ready(out_rsp.ready), .out_sum(sums)
  );

  // Unused lanes read zero.
  always_comb begin
    sums_all = '0;
    for (int i = 0; i < LANES; i++) begin
      sums_all[i] = sums[i];
    end
  end

  assign out_rsp.sum_lane0 = sums_all[0];
  assign out_rsp.sum_lane1 = sums_all[1];
  assign out_rsp.sum_lane2 = sums_all[2];
  assign out_rsp.sum_lane3 = sums_all[3];
  assign out_rsp.sum_lane4 = sums_all[4];
  assign out_rsp.sum_lane5 = sums_all[5];
  assign out_rsp.sum_lane6 = sums_all[6];
  assign out_rsp.sum_lane7 = sums_all[7];

endmodule

`default_nettype wire

// ===== src/mha_front.sv =====
// Front end: accepts record words, scrambles them in two multiply stages
// and folds them into the lane hashes. Depends on mha_pkg and mha_ifs.
`default_nettype none

module mha_front #(
  parameter int LANES = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  mha_in_if.sink                        in_req,
  input  wire mha_pkg::fifo_stat_t      q_stat,
  output logic                          q_push,
  output logic [LANES-1:0][31:0]        q_hash,
  output logic [31:0]                   q_len,
  output logic                          q_mode
);
  import mha_pkg::*;

  logic              s1_valid_r, s2_valid_r;
  logic              s1_last_r, s2_last_r;
  logic              s1_mode_r, s2_mode_r;
  logic              s1_full_r, s2_full_r;
  logic              s1_part_r, s2_part_r;
  logic [2:0]        s1_add_r, s2_add_r;
  logic [31:0]       s1_k_r, s2_k_r;
  logic [LANES-1:0][31:0] hash_r, hash_nxt, hash_upd;
  logic [31:0]       len_r, len_nxt, len_upd;
  logic              adv;
  logic              acc;
  logic [31:0]       w_mask;
  logic              in_full, in_part;
  logic [31:0]       k1_rot;

  // The pipeline only halts when a finished record cannot enter the queue.
  assign adv          = !(s2_valid_r && s2_last_r && q_stat.full);
  assign in_req.ready = adv;
  assign acc          = in_req.valid && adv;

  // Classify the word: full block, partial tail, or nothing to mix.
  always_comb begin
    in_full = !in_req.last_word || (in_req.valid_bytes >= 3'd4);
    in_part = in_req.last_word && (in_req.valid_bytes != 3'd0) &&
              (in_req.valid_bytes < 3'd4);
    case (in_req.valid_bytes)
      3'd1:    w_mask = {24'd0, in_req.data_word[7:0]};
      3'd2:    w_mask = {16'd0, in_req.data_word[15:0]};
      3'd3:    w_mask = {8'd0, in_req.data_word[23:0]};
      default: w_mask = in_req.data_word;
    endcase
    if (in_full) begin
      w_mask = in_req.data_word;
    end
  end

  assign k1_rot = {s1_k_r[16:0], s1_k_r[31:17]};

  // Lane update from the word in the last stage.
  always_comb begin
    logic [31:0] t;
    for (int i = 0; i < LANES; i++) begin
      t = hash_r[i] ^ (s2_k_r + LANE_DELTA[i]);
      t = {t[18:0], t[31:19]};
      if (s2_full_r) begin
        hash_upd[i] = {t[29:0], 2'b00} + t + C_MIX_ADD;
      end else if (s2_part_r) begin
        hash_upd[i] = hash_r[i] ^ s2_k_r;
      end else begin
        hash_upd[i] = hash_r[i];
      end
    end
    len_upd = len_r + {29'd0, s2_add_r};
    hash_nxt = hash_r;
    len_nxt  = len_r;
    if (adv && s2_valid_r) begin
      hash_nxt = hash_upd;
      len_nxt  = len_upd;
      if (s2_last_r) begin
        for (int i = 0; i < LANES; i++) begin
          hash_nxt[i] = LANE_SEED[i];
        end
        len_nxt = 32'd0;
      end
    end
  end

  assign q_push = adv && s2_valid_r && s2_last_r;
  assign q_hash = hash_upd;
  assign q_len  = len_upd;
  assign q_mode = s2_mode_r;

  // Control state of the stages and the record state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      len_r      <= 32'd0;
      for (int i = 0; i < LANES; i++) begin
        hash_r[i] <= LANE_SEED[i];
      end
    end else begin
      hash_r <= hash_nxt;
      len_r  <= len_nxt;
      if (adv) begin
        s1_valid_r <= acc;
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  // Stage payload; each stage holds one multiplier result.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_k_r    <= w_mask * C_SCR1;
      s1_last_r <= in_req.last_word;
      s1_mode_r <= in_req.mode;
      s1_full_r <= in_full;
      s1_part_r <= in_part;
      s1_add_r  <= in_full ? 3'd4 : (in_part ? in_req.valid_bytes : 3'd0);
      s2_k_r    <= k1_rot * C_SCR2;
      s2_last_r <= s1_last_r;
      s2_mode_r <= s1_mode_r;
      s2_full_r <= s1_full_r;
      s2_part_r <= s1_part_r;
      s2_add_r  <= s1_add_r;
    end
  end

endmodule

`default_nettype wire

// ===== src/mha_fifo.sv =====
// Two-entry queue that carries finished lane hashes from the front end
// to the back end. Depends on mha_pkg.
`default_nettype none

module mha_fifo #(
  parameter int W = 290
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire logic [W-1:0]    push_data,
  input  wire logic            pop,
  output logic [W-1:0]         pop_data,
  output mha_pkg::fifo_stat_t  stat
);
  import mha_pkg::*;

  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign pop_data   = mem_r[rp_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== src/mha_back.sv =====
// Back end: finalizes each lane hash, reduces it with a bit-serial
// remainder unit per lane and updates the running sums. Depends on mha_pkg.
`default_nettype none

module mha_back #(
  parameter int LANES = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire mha_pkg::fifo_stat_t      q_stat,
  output logic                          q_pop,
  input  wire logic [LANES-1:0][31:0]   q_hash,
  input  wire logic [31:0]              q_len,
  input  wire logic                     q_mode,
  input  wire logic [LANES-1:0][31:0]   modulus,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [LANES-1:0][31:0]        out_sum
);
  import mha_pkg::*;

  back_state_t            state_r, state_nxt;
  logic [STEP_W-1:0]      cnt_r;
  logic                   mode_r;
  logic [LANES-1:0][31:0] a_r;
  logic [LANES-1:0][33:0] d_r, rem_r, rem_step;
  logic [LANES-1:0][31:0] sum_r;
  logic [LANES-1:0][32:0] m33;
  logic                   out_valid_r;
  logic [LANES-1:0][31:0] out_sum_r;
  logic                   step_last;
  logic                   slot_free;

  assign step_last = (cnt_r == STEP_W'(DIV_STEPS - 1));
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_sum   = out_sum_r;

  // One restoring remainder step per lane; modulus zero stands for 2^32.
  always_comb begin
    logic [33:0] r2;
    for (int i = 0; i < LANES; i++) begin
      m33[i] = {(modulus[i] == 32'd0), modulus[i]};
      r2 = {rem_r[i][32:0], d_r[i][33]};
      rem_step[i] = (r2 >= {1'b0, m33[i]}) ? (r2 - {1'b0, m33[i]}) : r2;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (!q_stat.empty) state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_DIV1;
      ST_DIV1: if (step_last) state_nxt = ST_ADJ;
      ST_ADJ:  state_nxt = ST_DIV2;
      ST_DIV2: if (step_last) state_nxt = ST_OUT;
      ST_OUT:  if (slot_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    q_pop = (state_r == ST_IDLE) && !q_stat.empty;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DIV1 || state_r == ST_DIV2) begin
        cnt_r <= step_last ? '0 : cnt_r + STEP_W'(1);
      end else begin
        cnt_r <= '0;
      end
      if (state_r == ST_DIV2 && step_last) begin
        for (int i = 0; i < LANES; i++) begin
          sum_r[i] <= rem_step[i][31:0];
        end
      end
      if (state_r == ST_OUT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Lane datapath: finalizer multiplies, then two remainder passes.
  always_ff @(posedge clk) begin
    logic [31:0] x;
    logic [32:0] v;
    for (int i = 0; i < LANES; i++) begin
      case (state_r)
        ST_IDLE: begin
          x = q_hash[i] ^ q_len;
          a_r[i] <= x ^ {16'd0, x[31:16]};
          if (q_pop) mode_r <= q_mode;
        end
        ST_MUL1: a_r[i] <= a_r[i] * C_FMIX1;
        ST_MUL2: a_r[i] <= (a_r[i] ^ {13'd0, a_r[i][31:13]}) * C_FMIX2;
        ST_FIN: begin
          d_r[i]   <= {2'b00, a_r[i] ^ {16'd0, a_r[i][31:16]}};
          rem_r[i] <= '0;
        end
        ST_DIV1, ST_DIV2: begin
          rem_r[i] <= rem_step[i];
          d_r[i]   <= {d_r[i][32:0], 1'b0};
        end
        ST_ADJ: begin
          v = rem_r[i][32:0];
          if (mode_r && v != 33'd0) begin
            v = m33[i] - v;
          end
          d_r[i]   <= {2'b00, sum_r[i]} + {1'b0, v};
          rem_r[i] <= '0;
        end
        ST_OUT: if (slot_free) out_sum_r[i] <= sum_r[i];
        default: a_r[i] <= a_r[i];
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV1 || state_r == ST_DIV2) |-> (rem_r[0][33] == 1'b0))
    else $error("remainder exceeds modulus range");
  a_sum_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |-> (modulus[0] == 32'd0 || sum_r[0] < modulus[0]))
    else $error("lane sum not reduced");
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result raised outside output step");
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (cnt_r == '0))
    else $error("step counter not cleared");
`endif

endmodule

`default_nettype wire
